[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ZGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed: lbl");

`define ZGD_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed: lbl");

`else

`define ZGD_ASSERT(lbl, clk, rstn, prop)

`define ZGD_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

[rtl/zgd_pkg.sv]
// types, constants and fibonacci table of the zeckendorf decomposer
`timescale 1ns / 1ps

package zgd_pkg;

  localparam int unsigned NumW = 32;
  localparam int unsigned PosW = 6;

  localparam logic [PosW-1:0] TopPos = 6'd47;
  localparam logic [PosW-1:0] MinPos = 6'd2;

  typedef struct packed {
    logic            vld;
    logic [NumW-1:0] value;
  } zgd_item_t;

  typedef struct packed {
    logic active;
  } zgd_status_t;

  function automatic logic [NumW-1:0] zgd_fib(input logic [PosW-1:0] k);
    logic [NumW-1:0] f;
    case (k)
      6'd0:    f = 32'd0;
      6'd1:    f = 32'd1;
      6'd2:    f = 32'd1;
      6'd3:    f = 32'd2;
      6'd4:    f = 32'd3;
      6'd5:    f = 32'd5;
      6'd6:    f = 32'd8;
      6'd7:    f = 32'd13;
      6'd8:    f = 32'd21;
      6'd9:    f = 32'd34;
      6'd10:   f = 32'd55;
      6'd11:   f = 32'd89;
      6'd12:   f = 32'd144;
      6'd13:   f = 32'd233;
      6'd14:   f = 32'd377;
      6'd15:   f = 32'd610;
      6'd16:   f = 32'd987;
      6'd17:   f = 32'd1597;
      6'd18:   f = 32'd2584;
      6'd19:   f = 32'd4181;
      6'd20:   f = 32'd6765;
      6'd21:   f = 32'd10946;
      6'd22:   f = 32'd17711;
      6'd23:   f = 32'd28657;
      6'd24:   f = 32'd46368;
      6'd25:   f = 32'd75025;
      6'd26:   f = 32'd121393;
      6'd27:   f = 32'd196418;
      6'd28:   f = 32'd317811;
      6'd29:   f = 32'd514229;
      6'd30:   f = 32'd832040;
      6'd31:   f = 32'd1346269;
      6'd32:   f = 32'd2178309;
      6'd33:   f = 32'd3524578;
      6'd34:   f = 32'd5702887;
      6'd35:   f = 32'd9227465;
      6'd36:   f = 32'd14930352;
      6'd37:   f = 32'd24157817;
      6'd38:   f = 32'd39088169;
      6'd39:   f = 32'd63245986;
      6'd40:   f = 32'd102334155;
      6'd41:   f = 32'd165580141;
      6'd42:   f = 32'd267914296;
      6'd43:   f = 32'd433494437;
      6'd44:   f = 32'd701408733;
      6'd45:   f = 32'd1134903170;
      6'd46:   f = 32'd1836311903;
      6'd47:   f = 32'd2971215073;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

endpackage

[rtl/zgd_front.sv]
// front end: accepts transactions, masks the number, drops zeros, two-entry queue
`timescale 1ns / 1ps

module zgd_front
  import zgd_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] number_i,
  output logic            busy_o,
  output zgd_item_t       item_o,
  input  logic            pop_i
);

  localparam logic [NumW-1:0] InMask =
    (WIDTH >= NumW) ? {NumW{1'b1}} : NumW'((65'd1 << WIDTH) - 65'd1);

  logic [NumW-1:0] mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [NumW-1:0] masked;
  logic            push;
  logic            pop;

  assign masked = number_i & InMask;
  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o && (masked != '0);
  assign pop    = pop_i && (cnt_q != 2'd0);

  assign item_o.vld   = (cnt_q != 2'd0);
  assign item_o.value = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= masked;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/zgd_back.sv]
// back end: greedy walk down the fibonacci table, one compare-subtract per cycle
`timescale 1ns / 1ps

module zgd_back
  import zgd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  zgd_item_t       item_i,
  output logic            pop_o,
  output zgd_status_t     status_o,
  output logic            result_valid_o,
  output logic [NumW-1:0] fib_term_o,
  output logic [PosW-1:0] fib_position_o,
  output logic            last_term_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic            state_q, state_d;
  logic [NumW-1:0] rem_q, rem_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            vld_q, vld_d;
  logic [NumW-1:0] term_q, term_d;
  logic [PosW-1:0] opos_q, opos_d;
  logic            last_q, last_d;
  logic [NumW-1:0] fib;
  logic            hit;
  logic            done;

  assign fib  = zgd_fib(pos_q);
  assign hit  = (fib <= rem_q);
  assign done = (rem_q == fib);

  assign pop_o           = (state_q == StIdle) && item_i.vld;
  assign status_o.active = (state_q == StRun);

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    vld_d   = 1'b0;
    term_d  = term_q;
    opos_d  = opos_q;
    last_d  = last_q;
    case (state_q)
      StIdle: begin
        if (item_i.vld) begin
          rem_d   = item_i.value;
          pos_d   = TopPos;
          state_d = StRun;
        end
      end
      StRun: begin
        if (hit) begin
          rem_d  = rem_q - fib;
          vld_d  = 1'b1;
          term_d = fib;
          opos_d = pos_q;
          last_d = done;
        end
        if ((hit && done) || (pos_q == MinPos)) begin
          state_d = StIdle;
        end else begin
          pos_d = pos_q - 6'd1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    term_q <= term_d;
    opos_q <= opos_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  assign result_valid_o = vld_q;
  assign fib_term_o     = term_q;
  assign fib_position_o = opos_q;
  assign last_term_o    = last_q;

endmodule

[rtl/zeckendorf_greedy_decomposer_core.sv]
// top level of the zeckendorf greedy decomposer
// the first term appears once the back end has popped the transaction and walked down to it, behind queued work
// the back end walks the table (F(47)..F(2)) for one item at a time and pops no new item until that walk ends
// a two-entry queue takes new transactions while the walk runs; busy_o while it is full
// results come out one per strobe; the receiver cannot stall, zero yields no result
// reset clears the queue and the walk at once; the table is constant
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zeckendorf_greedy_decomposer_core
  import zgd_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [NumW-1:0] number_i,
  output logic            result_valid_o,
  output logic [NumW-1:0] fib_term_o,
  output logic [PosW-1:0] fib_position_o,
  output logic            last_term_o
);

  zgd_item_t   item;
  zgd_status_t status;
  logic        pop;

  zgd_front #(
    .WIDTH(WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .number_i(number_i),
    .busy_o  (busy_o),
    .item_o  (item),
    .pop_i   (pop)
  );

  zgd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .pop_o         (pop),
    .status_o      (status),
    .result_valid_o(result_valid_o),
    .fib_term_o    (fib_term_o),
    .fib_position_o(fib_position_o),
    .last_term_o   (last_term_o)
  );

  `ZGD_ASSERT(a_term_range, clk_i, rst_ni, result_valid_o |-> (fib_term_o != '0) && (fib_position_o >= MinPos) && (fib_position_o <= TopPos))
  `ZGD_ASSERT(a_no_adjacent, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  `ZGD_ASSERT(a_full_valid, clk_i, rst_ni, busy_o |-> item.vld)
  `ZGD_ASSERT(a_pop_idle, clk_i, rst_ni, pop |-> !status.active && item.vld)

endmodule
